// ===== rtl/core/tdf_pkg.sv =====
// shared constants, types and microcode table of the trial division factorizer
package tdf_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int IN_W        = 32;
	localparam int PRIME_W     = 32;
	localparam int EXP_W       = 5;

	typedef enum logic [3:0] {
		S_IDLE  = 4'd0,
		S_CHK1  = 4'd1,
		S_TRY   = 4'd2,
		S_TWAIT = 4'd3,
		S_TEST  = 4'd4,
		S_TDIV  = 4'd5,
		S_TAKE  = 4'd6,
		S_RWAIT = 4'd7,
		S_RTEST = 4'd8,
		S_EMITP = 4'd9,
		S_AFTER = 4'd10,
		S_INC   = 4'd11,
		S_REM   = 4'd12,
		S_RDONE = 4'd13,
		S_ONE   = 4'd14,
		S_ODONE = 4'd15
	} step_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_IN,
		C_N_LE1,
		C_DIV_BUSY,
		C_Q_LT_P,
		C_R_NZ,
		C_R_Z,
		C_OUT_HOLD,
		C_N_EQ1
	} cond_t;

	typedef enum logic [1:0] {
		OS_NONE,
		OS_FACTOR,
		OS_REM,
		OS_ONE
	} out_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     div_start;
		logic     clr_e;
		logic     take;
		logic     inc_p;
		out_sel_t out_sel;
		cond_t    cond;
		step_t    target;
	} ctrl_t;

	// control word for each step: jump to target when cond holds, else fall through
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{in_ready: 1'b0, div_start: 1'b0, clr_e: 1'b0, take: 1'b0, inc_p: 1'b0,
			out_sel: OS_NONE, cond: C_NONE, target: S_IDLE};
		unique case (s)
			S_IDLE: begin
				w.in_ready = 1'b1;
				w.cond     = C_NO_IN;
				w.target   = S_IDLE;
			end
			S_CHK1: begin
				w.cond   = C_N_LE1;
				w.target = S_ONE;
			end
			S_TRY: begin
				w.div_start = 1'b1;
				w.clr_e     = 1'b1;
			end
			S_TWAIT: begin
				w.cond   = C_DIV_BUSY;
				w.target = S_TWAIT;
			end
			S_TEST: begin
				w.cond   = C_Q_LT_P;
				w.target = S_REM;
			end
			S_TDIV: begin
				w.cond   = C_R_NZ;
				w.target = S_INC;
			end
			S_TAKE: begin
				w.take      = 1'b1;
				w.div_start = 1'b1;
			end
			S_RWAIT: begin
				w.cond   = C_DIV_BUSY;
				w.target = S_RWAIT;
			end
			S_RTEST: begin
				w.cond   = C_R_Z;
				w.target = S_TAKE;
			end
			S_EMITP: begin
				w.out_sel = OS_FACTOR;
				w.cond    = C_OUT_HOLD;
				w.target  = S_EMITP;
			end
			S_AFTER: begin
				w.cond   = C_N_EQ1;
				w.target = S_IDLE;
			end
			S_INC: begin
				w.inc_p  = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = S_TRY;
			end
			S_REM: begin
				w.out_sel = OS_REM;
				w.cond    = C_OUT_HOLD;
				w.target  = S_REM;
			end
			S_RDONE: begin
				w.cond   = C_ALWAYS;
				w.target = S_IDLE;
			end
			S_ONE: begin
				w.out_sel = OS_ONE;
				w.cond    = C_OUT_HOLD;
				w.target  = S_ONE;
			end
			S_ODONE: begin
				w.cond   = C_ALWAYS;
				w.target = S_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/trial_division_factorizer.sv =====
// top level: microcoded trial division prime factorizer
// inputs 0 and 1 skip the trial loop and give a single result; otherwise each trial divisor
//   runs one division on the bit-serial divider, plus one more division per power removed,
//   so a 32-bit input tries up to roughly 65536 trial divisors
// one item at a time: a new value is taken only in the idle step, after the last result
// reset: arst_n clears the step counter to idle and stops the divider
module trial_division_factorizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tdf_pkg::IN_W-1:0]    value_to_factor,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tdf_pkg::PRIME_W-1:0] prime,
	output logic [tdf_pkg::EXP_W-1:0]   exponent,
	output logic                        last
);
	import tdf_pkg::*;

	localparam int VW = VALUE_WIDTH;

	// sequencer state
	step_t pc_q;
	step_t pc_next;
	ctrl_t ctrl;
	logic  jump;

	// datapath registers: remaining value, candidate divisor, exponent count
	logic [VW-1:0]    n_q;
	logic [VW-1:0]    p_q;
	logic [EXP_W-1:0] e_q;

	// divider interface
	logic          div_busy;
	logic [VW-1:0] div_quo;
	logic [VW-1:0] div_rem;
	logic [VW-1:0] div_dividend;

	logic accept_in;
	logic n_is_one;

	assign accept_in = in_valid && ctrl.in_ready;
	assign n_is_one  = (n_q == VW'(1));

	// control word for the current step
	always_comb begin
		ctrl = ucode(pc_q);
	end

	// condition select and next step
	always_comb begin
		case (ctrl.cond)
			C_NONE:     jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_IN:    jump = !in_valid;
			C_N_LE1:    jump = (n_q <= VW'(1));
			C_DIV_BUSY: jump = div_busy;
			C_Q_LT_P:   jump = (div_quo < p_q);      // candidate squared exceeds n
			C_R_NZ:     jump = (div_rem != '0);
			C_R_Z:      jump = (div_rem == '0);
			C_OUT_HOLD: jump = !out_ready;
			C_N_EQ1:    jump = n_is_one;
			default:    jump = 1'b0;
		endcase
		pc_next = jump ? ctrl.target : step_t'(pc_q + 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// datapath updates under microcode control
	always_ff @(posedge clk) begin
		if (accept_in) begin
			n_q <= VW'(value_to_factor);
			p_q <= VW'(2);
		end
		if (ctrl.inc_p) begin
			p_q <= p_q + VW'(1);
		end
		if (ctrl.clr_e) begin
			e_q <= '0;
		end
		// exact division: keep the quotient and count one more power
		if (ctrl.take) begin
			n_q <= div_quo;
			e_q <= e_q + EXP_W'(1);
		end
	end

	// after a take the next division runs on the fresh quotient
	assign div_dividend = ctrl.take ? div_quo : n_q;

	tdf_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.div_start),
		.dividend  (div_dividend),
		.divisor   (p_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// result selection; a factor is last when nothing of n remains
	always_comb begin
		out_valid = (ctrl.out_sel != OS_NONE);
		case (ctrl.out_sel)
			OS_FACTOR: begin
				prime    = PRIME_W'(p_q);
				exponent = e_q;
				last     = n_is_one;
			end
			OS_REM: begin
				prime    = PRIME_W'(n_q);
				exponent = EXP_W'(1);
				last     = 1'b1;
			end
			OS_ONE: begin
				prime    = '0;
				exponent = '0;
				last     = 1'b1;
			end
			default: begin
				prime    = '0;
				exponent = '0;
				last     = 1'b0;
			end
		endcase
	end

	assign in_ready = ctrl.in_ready;

endmodule

// ===== rtl/core/tdf_divider.sv =====
// restoring divider, one quotient bit per cycle
module tdf_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tdf_pkg::VALUE_WIDTH-1:0] dividend,
	input  logic [tdf_pkg::VALUE_WIDTH-1:0] divisor,
	output logic                            busy,
	output logic [tdf_pkg::VALUE_WIDTH-1:0] quotient,
	output logic [tdf_pkg::VALUE_WIDTH-1:0] remainder
);
	import tdf_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int CNT_W = $clog2(VW);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    quo_q;
	logic [VW-1:0]    div_q;

	logic [VW:0]      shifted;
	logic [VW:0]      diff;
	logic             ge;
	logic [VW-1:0]    rem_next;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		shifted  = {rem_q, quo_q[VW-1]};
		diff     = shifted - {1'b0, div_q};
		ge       = !diff[VW];
		rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(VW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[VW-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== bench/factor_checker.sv =====
`timescale 1ns / 1ps
// checker: predicts the prime factors of each accepted value and compares every result
module factor_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [tdf_pkg::IN_W-1:0]    value_to_factor,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [tdf_pkg::PRIME_W-1:0] prime,
	input  logic [tdf_pkg::EXP_W-1:0]   exponent,
	input  logic                        last,
	output int                          mismatch_count,
	output int                          pending
);
	import tdf_pkg::*;

	typedef struct packed {
		logic [IN_W-1:0]    source;
		logic [PRIME_W-1:0] prime;
		logic [EXP_W-1:0]   exponent;
		logic               last;
	} factor_t;

	factor_t expected_factors[$];
	int      mismatches  = 0;
	int      outstanding = 0;

	assign mismatch_count = mismatches;
	assign pending        = outstanding;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// trial division over the used value bits, one entry per distinct prime (one zero entry for 0 and 1)
	function automatic void predict_factors(input logic [IN_W-1:0] value);
		longint unsigned n;
		longint unsigned p;
		int unsigned     e;
		factor_t         found[$];
		n = 64'(value) & ((~64'd0) >> (64 - VALUE_WIDTH));
		if (n <= 1) begin
			found.push_back('{value, PRIME_W'(0), EXP_W'(0), 1'b1});
		end else begin
			for (p = 2; p <= n / p; p++) begin
				if (n % p != 0)
					continue;
				e = 0;
				while (n % p == 0) begin
					n = n / p;
					e++;
				end
				found.push_back('{value, PRIME_W'(p), EXP_W'(e), 1'b0});
			end
			// leftover above one is itself prime
			if (n != 1)
				found.push_back('{value, PRIME_W'(n), EXP_W'(1), 1'b0});
			found[found.size()-1].last = 1'b1;
		end
		foreach (found[i])
			expected_factors.push_back(found[i]);
	endfunction

	always @(posedge clk) begin
		factor_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_factors(value_to_factor);
			if (out_valid && out_ready) begin
				if (expected_factors.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: prime %0d exponent %0d last %0b",
						prime, exponent, last));
				end else begin
					want = expected_factors.pop_front();
					if (prime !== want.prime)
						report_mismatch($sformatf("value %0d: prime %0d, want %0d",
							want.source, prime, want.prime));
					if (exponent !== want.exponent)
						report_mismatch($sformatf("value %0d prime %0d: exponent %0d, want %0d",
							want.source, want.prime, exponent, want.exponent));
					if (last !== want.last)
						report_mismatch($sformatf("value %0d prime %0d: last %0b, want %0b",
							want.source, want.prime, last, want.last));
				end
			end
		end
		outstanding <= expected_factors.size();
	end

endmodule

// ===== bench/tb_trial_division_factorizer.sv =====
`timescale 1ns / 1ps
// testbench top: drives values into the factorizer, stalls its output and gives the verdict
module tb_trial_division_factorizer;
	import tdf_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 100;
	// slowest item here is about 1024 trial divisors
	localparam int STALL_LIMIT  = 250000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint unsigned MAX_VALUE = (64'd1 << IN_W) - 1;

	// receiver behavior, switched at random
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_CHOKE
	} rx_mode_t;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_ready;
	logic [IN_W-1:0]    value_to_factor = '0;
	logic               out_valid;
	logic               out_ready       = 1'b0;
	logic [PRIME_W-1:0] prime;
	logic [EXP_W-1:0]   exponent;
	logic               last;

	int       mismatch_count;
	int       pending;
	int       burst_left  = 0;
	int       idle_cycles = 0;
	rx_mode_t rx_mode     = RX_OPEN;
	int       rx_left     = 0;

	logic [IN_W-1:0] directed_values[$];

	trial_division_factorizer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.value_to_factor (value_to_factor),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.prime           (prime),
		.exponent        (exponent),
		.last            (last)
	);

	factor_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.value_to_factor (value_to_factor),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.prime           (prime),
		.exponent        (exponent),
		.last            (last),
		.mismatch_count  (mismatch_count),
		.pending         (pending)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: open stretches, coin-flip stretches and mostly-stalled stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_CHOKE));
			rx_left = $urandom_range(4, 64);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN: begin
				out_ready <= 1'b1;
			end
			RX_COIN: begin
				out_ready <= ($urandom_range(0, 1) == 1);
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// watchdog: a long run of cycles with no item moving on either side means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// offer one value; bursts of back-to-back items separated by random gaps
	// returns at the edge where the item is accepted
	task automatic send_value(input logic [IN_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			// a quarter of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid        <= 1'b1;
		value_to_factor <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// random value kept cheap to factor: a small core, mostly below 4096, scaled by
	// small primes, so the trial loop never runs far past 256 even for 32-bit values
	function automatic logic [IN_W-1:0] random_value();
		longint unsigned v;
		longint unsigned m;
		int unsigned     mults;
		int unsigned     pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return IN_W'($urandom_range(0, 3));
		v = (pick < 3) ? $urandom_range(2, 65535) : $urandom_range(1, 4095);
		mults = $urandom_range(0, 30);
		repeat (mults) begin
			case ($urandom_range(0, 5))
				0: m = 2;
				1: m = 3;
				2: m = 5;
				3: m = 7;
				4: m = 11;
				default: m = 13;
			endcase
			if (v * m <= MAX_VALUE)
				v = v * m;
		end
		return IN_W'(v);
	endfunction

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		directed_values = '{
			32'd1,              // one: single empty result
			32'd0,              // zero: treated like one
			32'd2,              // smallest prime
			32'd3,
			32'd4,              // prime square at the loop bound
			32'd6,
			32'd8,
			32'd25,
			32'd49,
			32'd97,
			32'd65521,          // prime left over as remainder
			32'd1042441,        // 1021 squared, long trial run
			32'd1048573,        // large prime remainder
			32'd4294955008,     // 2^12 times a large prime, high bits set
			32'd223092870,      // product of the first nine primes: most results
			32'd3486784401,     // 3^20, large exponent
			32'h8000_0000,      // 2^31, largest exponent
			32'hFFFF_FFFF,      // all ones
			32'hAAAA_AAAA,
			32'd4294836225      // 65535 squared
		};
		foreach (directed_values[i])
			send_value(directed_values[i]);

		repeat (RANDOM_ITEMS)
			send_value(random_value());
		in_valid <= 1'b0;

		// checker count is registered at the edge where an item moves
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// catch any result the block sends beyond its last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
